[sv/ple_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  // Field widths of the item and result beats
  localparam int MODE_W   = 2;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   result_data;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    entry_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take a new item beat
    logic start;    // set the walk index, read the entry at position
    logic capture;  // keep the read word as result
    logic step_rd;  // read the neighbour of the walk index
    logic step_wr;  // write the neighbour word, move the index on
    logic place;    // write the inserted word at the index
    logic finish;   // commit the count, load the result register
  } ple_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_ok;
    logic ins_ok;
    logic rem_ok;
    logic at_end;
  } ple_stat_t;

endpackage

`default_nettype wire

[sv/ple_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/ple_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire ple_stat_t stat,
  output ple_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RWAIT  = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_MVWR   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.rd_ok || stat.rem_ok) begin
          cmd.start = 1'b1;
          state_nxt = S_RWAIT;
        end else if (stat.ins_ok) begin
          cmd.start = 1'b1;
          state_nxt = S_MOVE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RWAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = stat.rem_ok ? S_MOVE : S_DONE;
      end
      S_MOVE: begin
        if (stat.at_end) begin
          cmd.place = stat.ins_ok;
          state_nxt = S_DONE;
        end else begin
          cmd.step_rd = 1'b1;
          state_nxt   = S_MVWR;
        end
      end
      S_MVWR: begin
        cmd.step_wr = 1'b1;
        state_nxt   = S_MOVE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/ple_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_dp
  import ple_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire ple_cmd_t cmd,
  output ple_stat_t     stat,
  output out_item_t     out_item
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  in_item_t              op_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         idx_inc, idx_dec;
  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] res_r;
  out_item_t             out_r;

  logic [DATA_WIDTH-1:0] in_word;
  logic [WORD_W-1:0]     res_word;
  logic [CMPW-1:0]       pos_x, cnt_x, new_x;
  logic                  pos_lt, pos_le, full;
  logic                  is_rd, is_ins, is_rem;
  logic [STATUS_W-1:0]   status;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // Word width conversion, both ways
  for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_in_bit
    if (b < WORD_W) begin : g_take
      assign in_word[b] = in_item.data[b];
    end else begin : g_zero
      assign in_word[b] = 1'b0;
    end
  end
  for (genvar b = 0; b < WORD_W; b++) begin : g_out_bit
    if (b < DATA_WIDTH) begin : g_take
      assign res_word[b] = res_r[b];
    end else begin : g_zero
      assign res_word[b] = 1'b0;
    end
  end

  // Range and fill checks on the held item
  assign pos_x  = CMPW'(op_r.position);
  assign cnt_x  = CMPW'(cnt_r);
  assign pos_lt = pos_x < cnt_x;
  assign pos_le = pos_x <= cnt_x;
  assign full   = (cnt_r == CW'(DEPTH));
  assign is_rd  = (op_r.mode == MODE_READ);
  assign is_ins = (op_r.mode == MODE_INSERT);
  assign is_rem = (op_r.mode == MODE_REMOVE);

  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;

  assign stat.rd_ok  = is_rd && pos_lt;
  assign stat.ins_ok = is_ins && pos_le && !full;
  assign stat.rem_ok = is_rem && pos_lt;
  // insert walks down to position; remove walks up to the last entry
  assign stat.at_end = is_ins ? (CMPW'(idx_r) == pos_x) : (idx_inc == cnt_r);

  always_comb begin
    case (op_r.mode)
      MODE_READ, MODE_REMOVE: status = pos_lt ? ST_DONE : ST_RANGE;
      MODE_INSERT: begin
        if (!pos_le) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status = ST_DONE;
        end
      end
      default: status = ST_RANGE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (stat.ins_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (stat.rem_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end
  assign new_x = CMPW'(cnt_nxt);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = is_ins ? cnt_r : pos_x[CW-1:0];
    end else if (cmd.step_wr) begin
      idx_nxt = is_ins ? idx_dec : idx_inc;
    end
  end

  // Entry store port selection
  assign ram_we    = cmd.step_wr || cmd.place;
  assign ram_waddr = idx_r[AW-1:0];
  assign ram_wdata = cmd.place ? word_r : ram_rdata;
  assign ram_raddr = cmd.step_rd ? (is_ins ? idx_dec[AW-1:0] : idx_inc[AW-1:0])
                   : pos_x[AW-1:0];

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Held item, walk index and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_item;
      word_r <= in_word;
      res_r  <= '0;
    end
    if (cmd.capture) begin
      res_r <= ram_rdata;
    end
    idx_r <= idx_nxt;
    if (cmd.finish) begin
      out_r.result_data <= res_word;
      out_r.status      <= status;
      out_r.entry_count <= new_x[POS_W-1:0];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.finish) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

[sv/positional_list_engine_unit.sv]
// Accept to result: an error or full status goes from decode to the result; a read or a
// remove first reads the entry; an insert or remove shifts the entries past position.
// One item at a time; in_ready returns in the cycle after the previous result is loaded.
// The shift walks the entry memory one entry at a time, each a read and then a write.
// Reset (rst_n, synchronous): count cleared, no result pending; entries are left unset.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

[sv/ple_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_chk
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // One item in flight: no accept straight after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // Failed operations return no word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_DONE |-> out_item.result_data == '0)
    else $error("word returned with a failing status");

  // Full status only when the list is at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> out_item.entry_count == FULL_CNT)
    else $error("full status with list below capacity");

  // Count never passes capacity
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 31) || (out_item.entry_count <= FULL_CNT))
    else $error("entry count above capacity");

endmodule

bind positional_list_engine_unit ple_chk #(.DEPTH(DEPTH)) u_ple_chk (.*);

`default_nettype wire
